// ----- rtl/sor_pkg.sv -----
// shared constants, types and helpers of the pressure relaxation block
`timescale 1ns / 1ps
package sor_pkg;
	localparam int GRID = 32;
	localparam int SIDE = GRID + 2;
	localparam int PDEPTH = SIDE * SIDE;
	localparam int CELLS = GRID * GRID;
	localparam int PADDR_W = $clog2(PDEPTH);
	localparam int RADDR_W = $clog2(CELLS);
	localparam int CRD_W = $clog2(SIDE);
	localparam int SQ_W = 47;
	localparam int SUM_W = SQ_W + $clog2(CELLS);
	// grid size is a power of two, so the mean over the cells is a shift
	localparam int CELL_SH = $clog2(CELLS);
	localparam int PROD_W = 66;

	localparam logic [1:0] ACT_WRITE = 2'd0;
	localparam logic [1:0] ACT_SWEEP = 2'd1;
	localparam logic [1:0] ACT_READ = 2'd2;

	localparam logic [1:0] CFG_RELAX = 2'd0;
	localparam logic [1:0] CFG_CELL_SQ = 2'd1;
	localparam logic [1:0] CFG_INV_SQ = 2'd2;

	typedef struct packed {
		logic [1:0] action;
		logic [5:0] cell_x;
		logic [5:0] cell_y;
		logic signed [31:0] pressure_in;
		logic signed [31:0] rhs_in;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] pressure_out;
		logic [30:0] residual_mean;
		logic bad_coordinate;
	} out_item_t;

	typedef struct packed {
		logic [17:0] relax_factor;
		logic [30:0] cell_size_sq;
		logic [30:0] inv_cell_size_sq;
	} cfg_t;

	typedef struct packed {
		logic start;
		logic signed [31:0] p;
		logic signed [31:0] e;
		logic signed [31:0] w;
		logic signed [31:0] n;
		logic signed [31:0] s;
		logic signed [31:0] r;
	} alu_req_t;

	typedef struct packed {
		logic done;
		logic signed [31:0] new_p;
		logic [SQ_W-1:0] r2;
	} alu_rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD_WAIT,
		ST_COPY_RD,
		ST_COPY_WR,
		ST_CELL_RD,
		ST_CELL_ALU,
		ST_DIV
	} state_t;

	function automatic logic signed [31:0] sat32(input logic signed [PROD_W:0] v);
		logic signed [PROD_W:0] smax;
		logic signed [PROD_W:0] smin;
		smax = 67'sd2147483647;
		smin = -67'sd2147483648;
		if (v > smax) return 32'sh7fffffff;
		if (v < smin) return 32'sh80000000;
		return v[31:0];
	endfunction
endpackage

// ----- rtl/sor_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps
module sor_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/sor_stencil_alu.sv -----
// per-cell stencil arithmetic over one shared multiplier, eight steps
`timescale 1ns / 1ps
module sor_stencil_alu (
	input  logic              clk,
	input  logic              arst_n,
	input  sor_pkg::cfg_t     cfg,
	input  sor_pkg::alu_req_t req,
	output sor_pkg::alu_rsp_t rsp
);
	logic busy_q;
	logic [2:0] step_q;
	logic signed [31:0] nbs_q, lap_q, d_q, rr_q, g_q;
	logic [sor_pkg::SQ_W-1:0] r2_q;
	logic signed [sor_pkg::PROD_W-1:0] prod_q, acc_q;
	logic signed [32:0] ma, mb;
	logic signed [sor_pkg::PROD_W-1:0] prod;
	logic signed [sor_pkg::PROD_W:0] nb_x, lap_x, q_x, np_x;

	assign nb_x = 67'(req.e) + 67'(req.w) + 67'(req.n) + 67'(req.s);
	assign lap_x = nb_x - (67'(req.p) <<< 2);
	// floor shift of the product, saturate, then subtract rhs
	assign q_x = 67'(sor_pkg::sat32(67'(prod_q >>> 16))) - 67'(req.r);
	assign np_x = (67'(acc_q) + 67'(prod_q)) >>> 16;

	always_comb begin
		ma = '0;
		mb = '0;
		case (step_q)
			3'd1: begin
				ma = 33'(nbs_q);
				mb = $signed({2'b0, cfg.inv_cell_size_sq});
			end
			3'd2: begin
				ma = 33'(lap_q);
				mb = $signed({2'b0, cfg.inv_cell_size_sq});
			end
			3'd3: begin
				ma = 33'(d_q);
				mb = $signed({2'b0, cfg.cell_size_sq});
			end
			3'd4: begin
				ma = 33'(rr_q);
				mb = 33'(rr_q);
			end
			3'd5: begin
				ma = 33'(g_q);
				mb = $signed({15'b0, cfg.relax_factor});
			end
			3'd6: begin
				ma = 33'(req.p);
				mb = 33'sd65536 - $signed({15'b0, cfg.relax_factor});
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	assign prod = ma * mb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 3'd1;
			if (step_q == 3'd7) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			prod_q <= prod;
			case (step_q)
				3'd0: begin
					nbs_q <= sor_pkg::sat32(nb_x);
					lap_q <= sor_pkg::sat32(lap_x);
				end
				3'd2: d_q <= sor_pkg::sat32(q_x);
				3'd3: rr_q <= sor_pkg::sat32(q_x);
				3'd4: g_q <= sor_pkg::sat32(67'(prod_q >>> 18));
				3'd5: r2_q <= prod_q[sor_pkg::SQ_W+15:16];
				3'd6: acc_q <= prod_q;
				default: begin
				end
			endcase
		end
	end

	assign rsp.done = busy_q && (step_q == 3'd7);
	assign rsp.new_p = sor_pkg::sat32(np_x);
	assign rsp.r2 = r2_q;
endmodule

// ----- rtl/sor_pressure_relaxation.sv -----
// top level: command decode, sweep sequencer, grid memories, residual mean
// sweep time is set by five serial pressure memory reads and eight
//   shared-multiplier steps per cell
// throughput: one transaction at a time, the next is taken once it is done
// reset: registers to defaults, then a clearing pass over all SIDE*SIDE
//   pressure entries zeroes both grids while no input is taken
`timescale 1ns / 1ps
module sor_pressure_relaxation (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  sor_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output sor_pkg::out_item_t out_data,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [30:0]        cfg_data
);
	localparam int PAW = sor_pkg::PADDR_W;
	localparam int RAW = sor_pkg::RADDR_W;
	localparam int CW = sor_pkg::CRD_W;
	localparam int CSH = sor_pkg::CELL_SH;

	function automatic logic [PAW-1:0] paddr(input int x, input int y);
		return PAW'(x * sor_pkg::SIDE + y);
	endfunction

	sor_pkg::state_t state_q, state_d;
	sor_pkg::cfg_t cfg_q;
	sor_pkg::alu_req_t req;
	sor_pkg::alu_rsp_t rsp;
	sor_pkg::out_item_t out_q, out_d;
	logic out_valid_q, out_load, accept, wr_ok, rd_ok;
	logic [PAW-1:0] clr_q;
	logic [CW-1:0] x_q, y_q, i_q;
	logic [2:0] k_q;
	logic [1:0] edge_q;
	logic signed [31:0] nbr_q [0:4];
	logic signed [31:0] rhs_q;
	logic [sor_pkg::SUM_W-1:0] sum_q;
	logic last_cell, last_copy;
	logic [PAW-1:0] cp_src, cp_dst, nb_addr, base_addr;

	logic p_we, r_we;
	logic [PAW-1:0] p_waddr, p_raddr;
	logic [RAW-1:0] r_waddr, r_raddr;
	logic [31:0] p_wdata, p_rdata, r_wdata, r_rdata;

	sor_ram #(.WIDTH(32), .DEPTH(sor_pkg::PDEPTH)) u_pgrid (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
		.raddr(p_raddr), .rdata(p_rdata)
	);

	sor_ram #(.WIDTH(32), .DEPTH(sor_pkg::CELLS)) u_rgrid (
		.clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
		.raddr(r_raddr), .rdata(r_rdata)
	);

	sor_stencil_alu u_alu (.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .req(req), .rsp(rsp));

	assign in_ready = (state_q == sor_pkg::ST_IDLE) && (!out_valid_q || out_ready);
	assign accept = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	assign wr_ok = (int'(in_data.cell_x) >= 1) && (int'(in_data.cell_x) <= sor_pkg::GRID)
		&& (int'(in_data.cell_y) >= 1) && (int'(in_data.cell_y) <= sor_pkg::GRID);
	assign rd_ok = (int'(in_data.cell_x) <= sor_pkg::GRID + 1)
		&& (int'(in_data.cell_y) <= sor_pkg::GRID + 1);

	assign last_cell = (x_q == CW'(sor_pkg::GRID)) && (y_q == CW'(sor_pkg::GRID));
	assign last_copy = (edge_q == 2'd3) && (i_q == CW'(sor_pkg::SIDE - 1));
	assign base_addr = paddr(int'(x_q), int'(y_q));

	// edge copies: bottom, left, top, right
	always_comb begin
		case (edge_q)
			2'd0: begin
				cp_src = paddr(int'(i_q), 1);
				cp_dst = paddr(int'(i_q), 0);
			end
			2'd1: begin
				cp_src = paddr(1, int'(i_q));
				cp_dst = paddr(0, int'(i_q));
			end
			2'd2: begin
				cp_src = paddr(int'(i_q), sor_pkg::GRID);
				cp_dst = paddr(int'(i_q), sor_pkg::GRID + 1);
			end
			default: begin
				cp_src = paddr(sor_pkg::GRID, int'(i_q));
				cp_dst = paddr(sor_pkg::GRID + 1, int'(i_q));
			end
		endcase
	end

	// read order per cell: center, east, west, north, south
	always_comb begin
		case (k_q)
			3'd1: nb_addr = paddr(int'(x_q) + 1, int'(y_q));
			3'd2: nb_addr = paddr(int'(x_q) - 1, int'(y_q));
			3'd3: nb_addr = paddr(int'(x_q), int'(y_q) + 1);
			3'd4: nb_addr = paddr(int'(x_q), int'(y_q) - 1);
			default: nb_addr = base_addr;
		endcase
	end

	assign req.p = nbr_q[4];
	assign req.e = nbr_q[3];
	assign req.w = nbr_q[2];
	assign req.n = nbr_q[1];
	assign req.s = nbr_q[0];
	assign req.r = rhs_q;

	always_comb begin
		state_d = state_q;
		p_we = 1'b0;
		p_waddr = paddr(int'(in_data.cell_x), int'(in_data.cell_y));
		p_wdata = in_data.pressure_in;
		p_raddr = paddr(int'(in_data.cell_x), int'(in_data.cell_y));
		r_we = 1'b0;
		r_waddr = RAW'((int'(in_data.cell_x) - 1) * sor_pkg::GRID + int'(in_data.cell_y) - 1);
		r_wdata = in_data.rhs_in;
		r_raddr = RAW'((int'(x_q) - 1) * sor_pkg::GRID + int'(y_q) - 1);
		req.start = 1'b0;
		out_load = 1'b0;
		out_d = '0;
		case (state_q)
			sor_pkg::ST_CLEAR: begin
				p_we = 1'b1;
				p_waddr = clr_q;
				p_wdata = '0;
				r_we = int'(clr_q) < sor_pkg::CELLS;
				r_waddr = RAW'(clr_q);
				r_wdata = '0;
				if (clr_q == PAW'(sor_pkg::PDEPTH - 1)) begin
					state_d = sor_pkg::ST_IDLE;
				end
			end
			sor_pkg::ST_IDLE: begin
				if (accept) begin
					case (in_data.action)
						sor_pkg::ACT_WRITE: begin
							p_we = wr_ok;
							r_we = wr_ok;
							out_load = 1'b1;
							out_d.bad_coordinate = !wr_ok;
						end
						sor_pkg::ACT_SWEEP: state_d = sor_pkg::ST_COPY_RD;
						sor_pkg::ACT_READ: begin
							if (rd_ok) begin
								state_d = sor_pkg::ST_RD_WAIT;
							end else begin
								out_load = 1'b1;
								out_d.bad_coordinate = 1'b1;
							end
						end
						default: out_load = 1'b1;
					endcase
				end
			end
			sor_pkg::ST_RD_WAIT: begin
				out_load = 1'b1;
				out_d.pressure_out = p_rdata;
				state_d = sor_pkg::ST_IDLE;
			end
			sor_pkg::ST_COPY_RD: begin
				p_raddr = cp_src;
				state_d = sor_pkg::ST_COPY_WR;
			end
			sor_pkg::ST_COPY_WR: begin
				p_we = 1'b1;
				p_waddr = cp_dst;
				p_wdata = p_rdata;
				state_d = last_copy ? sor_pkg::ST_CELL_RD : sor_pkg::ST_COPY_RD;
			end
			sor_pkg::ST_CELL_RD: begin
				p_raddr = nb_addr;
				if (k_q == 3'd5) begin
					req.start = 1'b1;
					state_d = sor_pkg::ST_CELL_ALU;
				end
			end
			sor_pkg::ST_CELL_ALU: begin
				if (rsp.done) begin
					p_we = 1'b1;
					p_waddr = base_addr;
					p_wdata = rsp.new_p;
					state_d = last_cell ? sor_pkg::ST_DIV : sor_pkg::ST_CELL_RD;
				end
			end
			sor_pkg::ST_DIV: begin
				// mean is the sum shifted down by log2 of the cell count, saturated to 31 bits
				out_load = 1'b1;
				out_d.residual_mean = (|sum_q[sor_pkg::SUM_W-1:CSH+31]) ? 31'h7fffffff
					: sum_q[CSH+30:CSH];
				state_d = sor_pkg::ST_IDLE;
			end
			default: state_d = sor_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sor_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.relax_factor <= 18'd65536;
			cfg_q.cell_size_sq <= 31'd65536;
			cfg_q.inv_cell_size_sq <= 31'd65536;
		end else if (cfg_we) begin
			case (cfg_index)
				sor_pkg::CFG_RELAX: cfg_q.relax_factor <= cfg_data[17:0];
				sor_pkg::CFG_CELL_SQ: cfg_q.cell_size_sq <= cfg_data;
				sor_pkg::CFG_INV_SQ: cfg_q.inv_cell_size_sq <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			x_q <= CW'(1);
			y_q <= CW'(1);
			i_q <= '0;
			k_q <= '0;
			edge_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				sor_pkg::ST_CLEAR: clr_q <= clr_q + PAW'(1);
				sor_pkg::ST_IDLE: begin
					edge_q <= '0;
					i_q <= '0;
				end
				sor_pkg::ST_COPY_WR: begin
					if (i_q == CW'(sor_pkg::SIDE - 1)) begin
						i_q <= '0;
						edge_q <= edge_q + 2'd1;
					end else begin
						i_q <= i_q + CW'(1);
					end
					x_q <= CW'(1);
					y_q <= CW'(1);
					k_q <= '0;
				end
				sor_pkg::ST_CELL_RD: k_q <= k_q + 3'd1;
				sor_pkg::ST_CELL_ALU: begin
					if (rsp.done) begin
						k_q <= '0;
						if (y_q == CW'(sor_pkg::GRID)) begin
							y_q <= CW'(1);
							x_q <= x_q + CW'(1);
						end else begin
							y_q <= y_q + CW'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= out_d;
		end
		if (state_q == sor_pkg::ST_CELL_RD && k_q != 3'd0) begin
			nbr_q[0] <= p_rdata;
			nbr_q[1] <= nbr_q[0];
			nbr_q[2] <= nbr_q[1];
			nbr_q[3] <= nbr_q[2];
			nbr_q[4] <= nbr_q[3];
			if (k_q == 3'd1) begin
				rhs_q <= r_rdata;
			end
		end
		if (accept) begin
			sum_q <= '0;
		end else if (state_q == sor_pkg::ST_CELL_ALU && rsp.done) begin
			sum_q <= sum_q + sor_pkg::SUM_W'(rsp.r2);
		end
	end

	// the output register is only ever full while the block waits for a new transaction
	a_out_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != sor_pkg::ST_IDLE) |-> !out_valid_q)
		else $error("result pending while a transaction is in progress");

	a_alu_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> (state_q == sor_pkg::ST_CELL_ALU))
		else $error("stencil unit finished outside the cell update");

	a_write_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_data.action == sor_pkg::ACT_WRITE) |=> out_valid_q)
		else $error("write transaction gave no result");

	a_cell_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sor_pkg::ST_CELL_RD) |-> (x_q >= CW'(1) && x_q <= CW'(sor_pkg::GRID)
		&& y_q >= CW'(1) && y_q <= CW'(sor_pkg::GRID)))
		else $error("sweep left the interior");
endmodule

// ----- bench/tb_sor_pressure_relaxation.sv -----
// self-checking bench for the pressure relaxation block: directed, then random transactions
`timescale 1ns / 1ps
module tb_sor_pressure_relaxation;
	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	sor_pkg::in_item_t in_data;
	logic out_valid;
	logic out_ready;
	sor_pkg::out_item_t out_data;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [30:0] cfg_data;

	sor_pressure_relaxation dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// own copy of the block state
	logic signed [31:0] pgrid [sor_pkg::PDEPTH];
	logic signed [31:0] rgrid [sor_pkg::CELLS];
	longint omega;
	longint h_sq;
	longint inv_h_sq;

	sor_pkg::in_item_t cmd_queue [$];
	sor_pkg::out_item_t expected_results [$];
	int errors;
	int sent;
	bit in_took;
	bit calm;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic longint clamp_s32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic int pix(int x, int y);
		return x * sor_pkg::SIDE + y;
	endfunction

	function automatic longint relax_sweep();
		longint sum, p, nb, rh, q, d, g, nv, lap, r;
		sum = 0;
		for (int x = 0; x < sor_pkg::SIDE; x++) pgrid[pix(x, 0)] = pgrid[pix(x, 1)];
		for (int y = 0; y < sor_pkg::SIDE; y++) pgrid[pix(0, y)] = pgrid[pix(1, y)];
		for (int x = 0; x < sor_pkg::SIDE; x++)
			pgrid[pix(x, sor_pkg::GRID + 1)] = pgrid[pix(x, sor_pkg::GRID)];
		for (int y = 0; y < sor_pkg::SIDE; y++)
			pgrid[pix(sor_pkg::GRID + 1, y)] = pgrid[pix(sor_pkg::GRID, y)];
		for (int x = 1; x <= sor_pkg::GRID; x++) begin
			for (int y = 1; y <= sor_pkg::GRID; y++) begin
				p = pgrid[pix(x, y)];
				nb = longint'(pgrid[pix(x + 1, y)]) + longint'(pgrid[pix(x - 1, y)])
					+ longint'(pgrid[pix(x, y + 1)]) + longint'(pgrid[pix(x, y - 1)]);
				rh = rgrid[(x - 1) * sor_pkg::GRID + (y - 1)];
				q = clamp_s32((clamp_s32(nb) * inv_h_sq) >>> 16);
				d = clamp_s32(q - rh);
				g = clamp_s32((d * h_sq) >>> 18);
				nv = clamp_s32((omega * g + (64'sd65536 - omega) * p) >>> 16);
				lap = clamp_s32(nb - 4 * p);
				r = clamp_s32(clamp_s32((lap * inv_h_sq) >>> 16) - rh);
				sum += (r * r) >> 16;
				pgrid[pix(x, y)] = nv[31:0];
			end
		end
		sum = sum / sor_pkg::CELLS;
		if (sum > 64'sd2147483647) sum = 64'sd2147483647;
		return sum;
	endfunction

	function automatic sor_pkg::out_item_t predict_cell_op(sor_pkg::in_item_t it);
		sor_pkg::out_item_t res;
		longint m;
		res = '0;
		case (it.action)
			sor_pkg::ACT_WRITE: begin
				if (it.cell_x >= 1 && it.cell_x <= sor_pkg::GRID
					&& it.cell_y >= 1 && it.cell_y <= sor_pkg::GRID) begin
					pgrid[pix(it.cell_x, it.cell_y)] = it.pressure_in;
					rgrid[(it.cell_x - 1) * sor_pkg::GRID + (it.cell_y - 1)] = it.rhs_in;
				end else begin
					res.bad_coordinate = 1'b1;
				end
			end
			sor_pkg::ACT_SWEEP: begin
				m = relax_sweep();
				res.residual_mean = m[30:0];
			end
			sor_pkg::ACT_READ: begin
				if (it.cell_x <= sor_pkg::GRID + 1 && it.cell_y <= sor_pkg::GRID + 1)
					res.pressure_out = pgrid[pix(it.cell_x, it.cell_y)];
				else
					res.bad_coordinate = 1'b1;
			end
			default: ;
		endcase
		return res;
	endfunction

	// driver: new item or idle at the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_took) begin
				if (cmd_queue.size() > 0 && (calm || $urandom_range(99) >= 36)) begin
					in_valid <= 1'b1;
					in_data <= cmd_queue.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= calm || $urandom_range(99) >= 36;
		end
	end

	// monitor: predict on input transaction, check on output transaction
	always @(posedge clk) begin
		in_took <= in_valid && in_ready;
		if (arst_n && in_valid && in_ready) begin
			expected_results.push_back(predict_cell_op(in_data));
			sent++;
		end
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result, actual %h", $realtime, out_data);
				errors++;
			end else begin
				sor_pkg::out_item_t e;
				e = expected_results.pop_front();
				if (out_data.pressure_out !== e.pressure_out) begin
					$display("%0t: pressure_out expected %h actual %h", $realtime,
						e.pressure_out, out_data.pressure_out);
					errors++;
				end
				if (out_data.residual_mean !== e.residual_mean) begin
					$display("%0t: residual_mean expected %h actual %h", $realtime,
						e.residual_mean, out_data.residual_mean);
					errors++;
				end
				if (out_data.bad_coordinate !== e.bad_coordinate) begin
					$display("%0t: bad_coordinate expected %b actual %b", $realtime,
						e.bad_coordinate, out_data.bad_coordinate);
					errors++;
				end
			end
		end
	end

	task automatic push_cmd(logic [1:0] act, int x, int y, logic [31:0] p, logic [31:0] r);
		sor_pkg::in_item_t it;
		it.action = act;
		it.cell_x = x[5:0];
		it.cell_y = y[5:0];
		it.pressure_in = p;
		it.rhs_in = r;
		cmd_queue.push_back(it);
	endtask

	task automatic drain();
		while (cmd_queue.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	task automatic set_reg(logic [1:0] idx, logic [30:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			sor_pkg::CFG_RELAX: omega = longint'(val[17:0]);
			sor_pkg::CFG_CELL_SQ: h_sq = longint'(val);
			default: inv_h_sq = longint'(val);
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [31:0] rand_value();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(1, 0) ? 32'h7fffffff : 32'h80000000;
			default: return $signed($urandom_range(262143)) - 131072;
		endcase
	endfunction

	// random phase: mostly interior writes and reads, a few sweeps
	task automatic random_phase(int count, int sweeps);
		int x, y, k;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(count - 1) < sweeps) begin
				push_cmd(sor_pkg::ACT_SWEEP, $urandom_range(63), $urandom_range(63),
					$urandom, $urandom);
				continue;
			end
			k = $urandom_range(99);
			x = (k % 10 == 0) ? $urandom_range(63) : $urandom_range(sor_pkg::SIDE - 1);
			y = (k % 7 == 0) ? $urandom_range(63) : $urandom_range(sor_pkg::SIDE - 1);
			if (k < 55) push_cmd(sor_pkg::ACT_WRITE, x, y, rand_value(), rand_value());
			else if (k < 96) push_cmd(sor_pkg::ACT_READ, x, y, $urandom, $urandom);
			else push_cmd(2'd3, x, y, $urandom, $urandom);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = sor_pkg::CFG_RELAX;
		cfg_data = '0;
		in_took = 1'b0;
		calm = 1'b0;
		errors = 0;
		sent = 0;
		omega = 65536;
		h_sq = 65536;
		inv_h_sq = 65536;
		foreach (pgrid[i]) pgrid[i] = '0;
		foreach (rgrid[i]) rgrid[i] = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: corners, border, out of range, every action
		push_cmd(sor_pkg::ACT_WRITE, 1, 1, 32'h7fffffff, 32'h80000000);
		push_cmd(sor_pkg::ACT_WRITE, sor_pkg::GRID, sor_pkg::GRID, 32'h80000000, 32'h7fffffff);
		push_cmd(sor_pkg::ACT_WRITE, 1, sor_pkg::GRID, 32'h00010000, 32'hffff0000);
		push_cmd(sor_pkg::ACT_WRITE, sor_pkg::GRID, 1, 32'hfffe0000, 32'h00020000);
		push_cmd(sor_pkg::ACT_WRITE, 0, 5, 32'h1234, 32'h5678);
		push_cmd(sor_pkg::ACT_WRITE, sor_pkg::GRID + 1, 5, 32'h1234, 32'h5678);
		push_cmd(sor_pkg::ACT_WRITE, 5, 63, 32'h1234, 32'h5678);
		push_cmd(sor_pkg::ACT_READ, 1, 1, 0, 0);
		push_cmd(sor_pkg::ACT_READ, sor_pkg::GRID, sor_pkg::GRID, 0, 0);
		push_cmd(sor_pkg::ACT_READ, 0, 0, 0, 0);
		push_cmd(sor_pkg::ACT_READ, sor_pkg::GRID + 1, sor_pkg::GRID + 1, 0, 0);
		push_cmd(sor_pkg::ACT_READ, sor_pkg::GRID + 2, 1, 0, 0);
		push_cmd(sor_pkg::ACT_READ, 63, 63, 0, 0);
		push_cmd(2'd3, 63, 63, 32'hffffffff, 32'hffffffff);
		push_cmd(sor_pkg::ACT_SWEEP, 0, 0, 0, 0);
		push_cmd(sor_pkg::ACT_READ, 0, 1, 0, 0);
		push_cmd(sor_pkg::ACT_READ, 1, 0, 0, 0);
		push_cmd(sor_pkg::ACT_READ, sor_pkg::GRID + 1, sor_pkg::GRID, 0, 0);
		push_cmd(sor_pkg::ACT_READ, 1, 1, 0, 0);
		push_cmd(sor_pkg::ACT_READ, 2, 2, 0, 0);
		drain();

		// extremes of the weights, omega zero and then above two
		set_reg(sor_pkg::CFG_RELAX, 31'd0);
		set_reg(sor_pkg::CFG_CELL_SQ, 31'h7fffffff);
		set_reg(sor_pkg::CFG_INV_SQ, 31'h7fffffff);
		random_phase(90, 2);
		drain();

		set_reg(sor_pkg::CFG_RELAX, 31'd262143);
		set_reg(sor_pkg::CFG_CELL_SQ, 31'd0);
		set_reg(sor_pkg::CFG_INV_SQ, 31'd0);
		calm = 1'b1;
		random_phase(90, 2);
		drain();
		calm = 1'b0;

		set_reg(sor_pkg::CFG_RELAX, 31'd131072);
		set_reg(sor_pkg::CFG_CELL_SQ, 31'd16384);
		set_reg(sor_pkg::CFG_INV_SQ, 31'd262144);
		random_phase(90, 2);
		drain();

		set_reg(sor_pkg::CFG_RELAX, 31'd98304);
		set_reg(sor_pkg::CFG_CELL_SQ, 31'd65536);
		set_reg(sor_pkg::CFG_INV_SQ, 31'd65536);
		random_phase(100, 3);
		drain();

		set_reg(sor_pkg::CFG_RELAX, 31'($urandom_range(131072)));
		set_reg(sor_pkg::CFG_CELL_SQ, 31'($urandom));
		set_reg(sor_pkg::CFG_INV_SQ, 31'($urandom_range(1 << 20)));
		random_phase(90, 2);
		drain();

		repeat (30) @(posedge clk);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#8_000_000;
		$display("end of test: mismatches");
		$finish;
	end
endmodule

// ----- sor_pressure_relaxation.f -----
rtl/sor_pkg.sv
rtl/sor_ram.sv
rtl/sor_stencil_alu.sv
rtl/sor_pressure_relaxation.sv
bench/tb_sor_pressure_relaxation.sv
